// ===== src/assert_macros.svh =====
// Assertion helpers for the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/qabb_pkg.sv =====
package qabb_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_EDGE_A = 2'd0;
    localparam logic [1:0] OP_EDGE_B = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // Field and datapath widths, sized for the largest legal parameters
    localparam int POS_W   = 32;
    localparam int INTV_W  = 18;
    localparam int DT_W    = 16;
    localparam int SUM_W   = 19;
    localparam int DIFF_W  = 35;
    localparam int MAG_W   = 34;
    localparam int NUM_W   = 54;
    localparam int SQ_W    = 38;
    localparam int CPR_W   = 16;
    localparam int DEN_W   = 54;
    localparam int PROD_W  = MAG_W + NUM_W;
    localparam int QUO_W   = 32;

    // Sequencer step counts
    localparam int MUL_STEPS = MAG_W / 2;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic prep;
        logic div_step;
    } t_dp_ctrl;

    // Sequencer status to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

endpackage

// ===== src/quadrature_accel_bang_bang_unit.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser opcode, tdata pins and ticks
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata result, tuser decision flag
// cfg       in   i_cfg_valid/o_cfg_ready          target acceleration, Q16.16
//
// Edge items and unused opcodes go straight to the output register; the result is valid in the next cycle.
// A sample tick runs one load, 17 radix-4 multiply steps, one divisor setup and 32
// restoring divide steps on the shared 88-bit adder, then writeback.
// Input is not ready while a sample is in flight or the output register is full
// and stalled. Reset is synchronous, active low; the cfg port is always ready.
`include "assert_macros.svh"

module quadrature_accel_bang_bang_unit import qabb_pkg::*; #(
    parameter int COUNTS_PER_REV = 2400,
    parameter int TICK_RATE      = 250000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] pin_a, [1] pin_b, [17:2] elapsed_ticks, [23:18] zero
    input  logic [23:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] position, [63:32] accel_estimate, [64] drive_reverse, [71:65] zero
    output logic [71:0] o_m_axis_tdata,
    // [0] decision_made
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [POS_W-1:0]  r_target;
    logic [POS_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_older;
    logic [POS_W-1:0]  r_newer;
    logic [INTV_W-1:0] r_interval;
    logic [POS_W-1:0]  r_accel;
    logic              r_reverse;
    logic [DT_W-1:0]   r_dt;
    logic              r_m_valid;
    logic [71:0]       r_m_data;
    logic              r_m_made;

    logic              w_s_acc;
    logic              w_start;
    logic              w_out_free;
    logic              w_pin_a;
    logic              w_pin_b;
    logic [DT_W-1:0]   w_dt;
    logic signed [DIFF_W-1:0] w_diff;
    logic [SUM_W-1:0]  w_sum;
    logic [POS_W-1:0]  w_est;
    logic              w_rev;
    t_dp_ctrl          w_ctrl;
    t_seq_stat         w_stat;

    assign w_pin_a = i_s_axis_tdata[0];
    assign w_pin_b = i_s_axis_tdata[1];
    assign w_dt    = i_s_axis_tdata[17:2];

    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = !w_stat.busy && w_out_free;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start         = w_s_acc && (i_s_axis_tuser == OP_SAMPLE);
    assign o_cfg_ready     = 1'b1;

    // Second difference on sign-extended positions, interval sum
    assign w_diff = DIFF_W'(signed'(r_count)) - (DIFF_W'(signed'(r_newer)) <<< 1)
                  + DIFF_W'(signed'(r_older));
    assign w_sum  = SUM_W'(r_interval) + SUM_W'(w_dt);

    // Step the position on an edge
    always_comb begin
        n_count = r_count;
        case (i_s_axis_tuser)
            OP_EDGE_A: n_count = (w_pin_a == w_pin_b) ? r_count - 1'b1 : r_count + 1'b1;
            OP_EDGE_B: n_count = (w_pin_a == w_pin_b) ? r_count + 1'b1 : r_count - 1'b1;
            default:   n_count = r_count;
        endcase
    end

    assign w_rev = (signed'(r_target) < signed'(w_est));

    qabb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl),
        .o_stat     (w_stat)
    );

    qabb_dp #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .TICK_RATE      (TICK_RATE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_diff     (w_diff),
        .i_sum      (w_sum),
        .o_estimate (w_est)
    );

    // Architectural state: config, position, sample history, decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= POS_W'(13107);
            r_count    <= '0;
            r_older    <= '0;
            r_newer    <= '0;
            r_interval <= INTV_W'(TICK_RATE);
            r_accel    <= '0;
            r_reverse  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
            if (w_s_acc) begin
                r_count <= n_count;
            end
            if (w_stat.done) begin
                r_accel    <= w_est;
                r_reverse  <= w_rev;
                r_older    <= r_newer;
                r_newer    <= r_count;
                r_interval <= INTV_W'(r_dt);
            end
        end
    end

    // Hold elapsed ticks for the end of the sample
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_dt <= w_dt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((w_s_acc && !w_start) || w_stat.done) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && !w_start) begin
            r_m_data <= {7'd0, r_reverse, r_accel, n_count};
            r_m_made <= 1'b0;
        end else if (w_stat.done) begin
            r_m_data <= {7'd0, w_rev, w_est, r_count};
            r_m_made <= 1'b1;
        end
    end

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = r_m_data;
    assign o_m_axis_tuser[0] = r_m_made;

    // Checks
    `ASSERT_IMPLY(a_busy_blocks_input, i_clk, i_rst_n, w_stat.busy, !o_s_axis_tready)
    `ASSERT_NEXT(a_sample_starts_seq, i_clk, i_rst_n, w_start, w_stat.busy)
    `ASSERT_NEXT(a_edge_result_next, i_clk, i_rst_n, w_s_acc && !w_start, r_m_valid && !r_m_made)

endmodule

// ===== src/qabb_seq.sv =====
module qabb_seq import qabb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_out_free,
    output t_dp_ctrl  o_ctrl,
    output t_seq_stat o_stat
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_ctrl      = '0;
        o_stat.busy = (r_state != ST_IDLE);
        o_stat.done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = ST_MUL;
                    n_step      = '0;
                end
            end
            ST_MUL: begin
                o_ctrl.mul_step = 1'b1;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = ST_PREP;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_PREP: begin
                o_ctrl.prep = 1'b1;
                n_state     = ST_DIV;
                n_step      = '0;
            end
            ST_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (i_out_free) begin
                    o_stat.done = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/qabb_dp.sv =====
module qabb_dp import qabb_pkg::*; #(
    parameter int COUNTS_PER_REV = 2400,
    parameter int TICK_RATE      = 250000
) (
    input  logic                     i_clk,
    input  t_dp_ctrl                 i_ctrl,
    input  logic signed [DIFF_W-1:0] i_diff,
    input  logic [SUM_W-1:0]         i_sum,
    output logic [POS_W-1:0]         o_estimate
);

    // Numerator constant 4 * TICK_RATE^2 * 65536 and its radix-4 multiples
    localparam logic [63:0]        K_TR64 = 64'(TICK_RATE);
    localparam logic [NUM_W-1:0]   K_NUM  = NUM_W'((K_TR64 * K_TR64) << 18);
    localparam logic [NUM_W+1:0]   K_NUM2 = (NUM_W + 2)'(K_NUM) << 1;
    localparam logic [NUM_W+1:0]   K_NUM3 = (NUM_W + 2)'(K_NUM) + K_NUM2;
    localparam logic [CPR_W-1:0]   K_CPR  = CPR_W'(COUNTS_PER_REV);

    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic              r_d_zero;
    logic              r_s_zero;
    logic [SUM_W-1:0]  r_s;
    logic [SQ_W-1:0]   r_sq;
    logic [DEN_W-1:0]  r_den;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_dvs;
    logic [QUO_W-1:0]  r_q;

    logic [PROD_W-1:0] w_a;
    logic [PROD_W-1:0] w_b;
    logic              w_sub;
    logic [PROD_W:0]   w_sum;
    logic              w_carry;
    logic [1:0]        w_digit;

    assign w_digit = r_mag[MAG_W-1 -: 2];

    // Shared wide adder: shift-add in multiply, trial subtract in divide
    always_comb begin
        w_a   = r_acc;
        w_b   = r_dvs;
        w_sub = 1'b1;
        if (i_ctrl.mul_step) begin
            w_a   = r_acc << 2;
            w_sub = 1'b0;
            case (w_digit)
                2'd0:    w_b = '0;
                2'd1:    w_b = PROD_W'(K_NUM);
                2'd2:    w_b = PROD_W'(K_NUM2);
                2'd3:    w_b = PROD_W'(K_NUM3);
                default: w_b = '0;
            endcase
        end
        w_sum = {1'b0, w_a} + {1'b0, w_b ^ {PROD_W{w_sub}}} + (PROD_W + 1)'(w_sub);
    end

    assign w_carry = w_sum[PROD_W];

    // Operand capture, multiply and divide iterations
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_neg    <= i_diff[DIFF_W-1];
            r_mag    <= MAG_W'(i_diff[DIFF_W-1] ? -i_diff : i_diff);
            r_d_zero <= (i_diff == '0);
            r_s      <= i_sum;
            r_s_zero <= (i_sum == '0);
            r_acc    <= '0;
        end
        if (i_ctrl.mul_step) begin
            r_acc <= w_sum[PROD_W-1:0];
            r_mag <= r_mag << 2;
            // divisor COUNTS_PER_REV * S^2 settles through r_sq then r_den during the multiply steps
            r_sq  <= SQ_W'(r_s) * SQ_W'(r_s);
            r_den <= DEN_W'(r_sq) * DEN_W'(K_CPR);
        end
        if (i_ctrl.prep) begin
            r_dvs <= PROD_W'(r_den) << (QUO_W - 1);
            r_q   <= '0;
        end
        if (i_ctrl.div_step) begin
            if (w_carry) begin
                r_acc <= w_sum[PROD_W-1:0];
            end
            r_q   <= {r_q[QUO_W-2:0], w_carry};
            r_dvs <= r_dvs >> 1;
        end
    end

    // Sign and saturate; top quotient bit set means magnitude reached 2^31
    always_comb begin
        if (r_d_zero) begin
            o_estimate = '0;
        end else if (r_s_zero || r_q[QUO_W-1]) begin
            o_estimate = r_neg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else if (r_neg) begin
            o_estimate = POS_W'(0) - r_q;
        end else begin
            o_estimate = r_q;
        end
    end

endmodule

// ===== test/tb.sv =====
module tb;
    import qabb_pkg::*;

    // Encoder and controller constants of the block under test
    localparam int unsigned CPR        = 2400;
    localparam int unsigned TICKS_PER_S = 250000;
    localparam logic [127:0] ACCEL_NUM = 128'd4 * TICKS_PER_S * TICKS_PER_S * 128'd65536;
    localparam logic [1:0]   OP_NONE   = 2'd3;
    localparam int           HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  op;
        logic        a;
        logic        b;
        logic [15:0] dt;
    } motion_item_t;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] accel;
        logic        rev;
        logic        made;
    } motion_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    // Predicted state of the decoder and controller
    logic [31:0] pos_cnt;
    logic [31:0] samp_old;
    logic [31:0] samp_new;
    logic [17:0] intv_q;
    logic [31:0] accel_q;
    logic        rev_q;
    logic [31:0] target_q;

    motion_item_t   motion_pend_q[$];
    motion_result_t motion_expect_q[$];
    motion_item_t   offered;
    motion_result_t mon_got;
    motion_result_t mon_want;

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_arm = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int n_items = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_targets = 0;

    // Random encoder walk
    logic [1:0] walk_idx = '0;
    logic       walk_dir = 1'b0;

    quadrature_accel_bang_bang_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Q16.16 acceleration from a second difference and an interval sum
    function automatic logic [31:0] accel_from(input logic signed [34:0] diff,
                                               input logic [18:0] span);
        logic [34:0]  mag;
        logic [127:0] den;
        logic [127:0] quo;
        if (diff == 0) return 32'h0;
        mag = diff[34] ? -diff : diff;
        den = 128'(CPR) * span * span;
        if (den == 0)
            quo = 128'h1_0000_0000;
        else
            quo = (128'(mag) * ACCEL_NUM) / den;
        if (!diff[34])
            return (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        return (quo >= 128'h8000_0000) ? 32'h8000_0000 : 32'h0 - quo[31:0];
    endfunction

    // Advance the predicted state by one transfer and return its result
    function automatic motion_result_t apply_motion(input motion_item_t it);
        logic signed [34:0] diff;
        logic [18:0]        span;
        motion_result_t     r;
        r.made = 1'b0;
        case (it.op)
            OP_EDGE_A: pos_cnt = (it.a == it.b) ? pos_cnt - 1 : pos_cnt + 1;
            OP_EDGE_B: pos_cnt = (it.a == it.b) ? pos_cnt + 1 : pos_cnt - 1;
            OP_SAMPLE: begin
                diff = $signed(pos_cnt) - ($signed(samp_new) <<< 1) + $signed(samp_old);
                span = {1'b0, intv_q} + {3'b0, it.dt};
                accel_q = accel_from(diff, span);
                samp_old = samp_new;
                samp_new = pos_cnt;
                intv_q = {2'b0, it.dt};
                rev_q = $signed(target_q) < $signed(accel_q);
                r.made = 1'b1;
            end
            default: ;
        endcase
        r.pos = pos_cnt;
        r.accel = accel_q;
        r.rev = rev_q;
        return r;
    endfunction

    // Next item of the random stream: mostly a clean quadrature walk
    function automatic motion_item_t next_motion();
        motion_item_t it;
        logic [1:0]   old_ab;
        logic [1:0]   new_ab;
        int unsigned  pick;
        pick = $urandom_range(99);
        it.dt = 16'($urandom);
        it.a = 1'($urandom);
        it.b = 1'($urandom);
        if (pick < 68) begin
            if ($urandom_range(15) == 0) walk_dir = ~walk_dir;
            old_ab = walk_idx[1] ? {1'b1 ^ walk_idx[0], 1'b1} : {walk_idx[0], 1'b0};
            walk_idx = walk_dir ? walk_idx - 2'd1 : walk_idx + 2'd1;
            new_ab = walk_idx[1] ? {1'b1 ^ walk_idx[0], 1'b1} : {walk_idx[0], 1'b0};
            it.a = new_ab[1];
            it.b = new_ab[0];
            it.op = (old_ab[1] != new_ab[1]) ? OP_EDGE_A : OP_EDGE_B;
        end else if (pick < 82) begin
            it.op = OP_SAMPLE;
            case ($urandom_range(7))
                0: it.dt = 16'h0;
                1: it.dt = 16'hFFFF;
                2, 3: it.dt = 16'($urandom_range(64, 1));
                default: ;
            endcase
        end else if (pick < 95) begin
            it.op = $urandom_range(1) ? OP_EDGE_B : OP_EDGE_A;
        end else begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    function automatic void push_motion(input logic [1:0] op, input logic a, input logic b,
                                        input logic [15:0] dt);
        motion_item_t it;
        it.op = op;
        it.a = a;
        it.b = b;
        it.dt = dt;
        motion_pend_q.push_back(it);
    endfunction

    // Input driver: offer queued items, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                motion_expect_q.push_back(apply_motion(offered));
                n_items++;
                if (offered.op == OP_SAMPLE) n_samples++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (motion_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = motion_pend_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {6'd0, offered.dt, offered.b, offered.a};
                    i_s_axis_tuser <= offered.op;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                mon_got.pos = o_m_axis_tdata[31:0];
                mon_got.accel = o_m_axis_tdata[63:32];
                mon_got.rev = o_m_axis_tdata[64];
                mon_got.made = o_m_axis_tuser[0];
                n_results++;
                if (motion_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result pos/accel/rev/made %h/%h/%b/%b", $time,
                             mon_got.pos, mon_got.accel, mon_got.rev, mon_got.made);
                end else begin
                    mon_want = motion_expect_q.pop_front();
                    if (mon_got !== mon_want) begin
                        errors++;
                        $display("%0t pos/accel/rev/made expected %h/%h/%b/%b got %h/%h/%b/%b",
                                 $time, mon_want.pos, mon_want.accel, mon_want.rev,
                                 mon_want.made, mon_got.pos, mon_got.accel, mon_got.rev,
                                 mon_got.made);
                    end
                end
            end
            i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // Wait until every item is accepted and every result checked
    task automatic wait_drained();
        do @(negedge i_clk);
        while (motion_pend_q.size() != 0 || i_s_axis_tvalid || motion_expect_q.size() != 0);
    endtask

    // Write the target acceleration while the block is idle
    task automatic write_target(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        target_q = value;
        n_targets++;
    endtask

    task automatic run_random(input int count, input int send_pct, input int stall);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        stall_pct = stall;
        repeat (count) motion_pend_q.push_back(next_motion());
        wait_drained();
    endtask

    initial begin
        pos_cnt = '0;
        samp_old = '0;
        samp_new = '0;
        intv_q = 18'(TICKS_PER_S);
        accel_q = '0;
        rev_q = 1'b0;
        target_q = 32'd13107;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero difference, every edge case, zero interval sum both signs
        @(negedge i_clk);
        push_motion(OP_SAMPLE, 1'b0, 1'b0, 16'h0);
        push_motion(OP_EDGE_A, 1'b0, 1'b0, 16'h0);
        push_motion(OP_EDGE_A, 1'b0, 1'b1, 16'h0);
        push_motion(OP_EDGE_A, 1'b1, 1'b0, 16'h0);
        push_motion(OP_EDGE_A, 1'b1, 1'b1, 16'h0);
        push_motion(OP_EDGE_B, 1'b0, 1'b0, 16'h0);
        push_motion(OP_EDGE_B, 1'b0, 1'b1, 16'h0);
        push_motion(OP_EDGE_B, 1'b1, 1'b0, 16'h0);
        push_motion(OP_EDGE_B, 1'b1, 1'b1, 16'h0);
        push_motion(OP_EDGE_B, 1'b1, 1'b1, 16'hFFFF);
        push_motion(OP_SAMPLE, 1'b1, 1'b1, 16'h0);
        push_motion(OP_EDGE_A, 1'b0, 1'b0, 16'h0);
        push_motion(OP_EDGE_A, 1'b0, 1'b0, 16'h0);
        push_motion(OP_SAMPLE, 1'b0, 1'b0, 16'h0);
        push_motion(OP_SAMPLE, 1'b1, 1'b0, 16'hFFFF);
        push_motion(OP_NONE, 1'b1, 1'b1, 16'hFFFF);
        push_motion(OP_NONE, 1'b0, 1'b0, 16'h0);
        push_motion(OP_SAMPLE, 1'b0, 1'b1, 16'h0001);
        push_motion(OP_EDGE_B, 1'b0, 1'b1, 16'h5555);
        push_motion(OP_SAMPLE, 1'b1, 1'b1, 16'hAAAA);
        wait_drained();

        // Random phases across target settings and idle patterns
        write_target(32'h7FFF_FFFF);
        run_random(150, 0, 0);
        write_target(32'h8000_0000);
        run_random(150, 57, 0);
        write_target($urandom);
        run_random(150, 0, 57);
        write_target(32'h0);
        run_random(150, 11, 11);

        // Receiver holds off while the sender keeps offering
        write_target(32'hFFFF_CCCD);
        @(negedge i_clk);
        hold_arm = 1'b1;
        @(negedge i_clk);
        hold_arm = 1'b0;
        run_random(60, 0, 0);

        repeat (60) @(posedge i_clk);
        $display("Checked %0d results for %0d items (%0d sample ticks) over %0d targets,",
                 n_results, n_items, n_samples, n_targets);
        $display("with idle, stall and long hold-off phases on both sides.");
        if (errors == 0 && motion_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
